[hdl/kmng_pkg.sv]
// Shared types and constants for the key to MIDI note generator.
package kmng_pkg;

    localparam int NUM_KEYS_DEF = 13;

    localparam logic [6:0] OCT_STEP    = 7'd12;
    localparam logic [6:0] FIFTH_UP    = 7'd19;
    localparam logic [6:0] RELEASE_VEL = 7'd64;
    localparam logic [6:0] BASE_MAX    = 7'd84;
    localparam logic [6:0] BASE_MIN    = 7'd36;
    localparam logic [6:0] VEL_RESET   = 7'd80;
    localparam logic [3:0] CHAN_RESET  = 4'd0;

    typedef enum logic [1:0] {
        ACT_KEY      = 2'd0,
        ACT_OCT_UP   = 2'd1,
        ACT_OCT_DOWN = 2'd2
    } t_action;

    typedef enum logic {
        REG_CHANNEL  = 1'b0,
        REG_VELOCITY = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        SLOT_ROOT   = 2'd0,
        SLOT_OCTAVE = 2'd1,
        SLOT_FIFTH  = 2'd2
    } t_slot;

    // One accepted key edge, waiting to be turned into messages.
    typedef struct packed {
        logic [6:0] note;
        logic       level;
        logic       chord;
    } t_job;

    // Handshake between the front end and the message emitter.
    typedef struct packed {
        logic load;
        t_job job;
    } t_job_req;

endpackage

[hdl/kmng_if.sv]
// Request and message channel interfaces of the key to MIDI note generator.
interface kmng_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] key;
    logic       level;
    logic       chord;

    modport source (output valid, action, key, level, chord, input ready);
    modport sink   (input valid, action, key, level, chord, output ready);
endinterface

interface kmng_msg_if;
    logic       valid;
    logic       ready;
    logic       note_on;
    logic [3:0] out_channel;
    logic [6:0] note;
    logic [6:0] out_velocity;
    logic       last;

    modport source (output valid, note_on, out_channel, note, out_velocity, last,
                    input ready);
    modport sink   (input valid, note_on, out_channel, note, out_velocity, last,
                    output ready);
endinterface

[hdl/kmng_emit.sv]
// Message emitter: job register, slot counter and registered message output.
module kmng_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kmng_pkg::t_job_req  i_job_req,
    input  logic [3:0]          i_channel,
    input  logic [6:0]          i_velocity,
    output logic                o_ready,
    kmng_msg_if.source          o_msg
);

    logic               r_job_valid;
    kmng_pkg::t_job     r_job;
    kmng_pkg::t_slot    r_slot;
    kmng_pkg::t_slot    n_slot;

    logic               r_out_valid;
    logic               r_note_on;
    logic [3:0]         r_channel;
    logic [6:0]         r_note;
    logic [6:0]         r_velocity;
    logic               r_last;

    logic               w_out_load;
    logic               w_job_last;
    logic [6:0]         w_offset;
    logic [6:0]         w_velocity;

    assign w_out_load = r_job_valid && (!r_out_valid || o_msg.ready);
    assign w_job_last = !r_job.chord || (r_slot == kmng_pkg::SLOT_FIFTH);
    assign o_ready    = !r_job_valid || (w_out_load && w_job_last);

    always_comb begin
        case (r_slot)
            kmng_pkg::SLOT_ROOT: begin
                w_offset   = 7'd0;
                w_velocity = r_job.level ? i_velocity : kmng_pkg::RELEASE_VEL;
                n_slot     = kmng_pkg::SLOT_OCTAVE;
            end
            kmng_pkg::SLOT_OCTAVE: begin
                w_offset   = kmng_pkg::OCT_STEP;
                w_velocity = i_velocity;
                n_slot     = kmng_pkg::SLOT_FIFTH;
            end
            kmng_pkg::SLOT_FIFTH: begin
                w_offset   = kmng_pkg::FIFTH_UP;
                w_velocity = i_velocity;
                n_slot     = kmng_pkg::SLOT_ROOT;
            end
            default: begin
                w_offset   = 7'd0;
                w_velocity = i_velocity;
                n_slot     = kmng_pkg::SLOT_ROOT;
            end
        endcase
    end

    // Job register: load a new edge, step through its slots, drop when done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_slot      <= kmng_pkg::SLOT_ROOT;
        end else if (i_job_req.load) begin
            r_job_valid <= 1'b1;
            r_slot      <= kmng_pkg::SLOT_ROOT;
        end else if (w_out_load && w_job_last) begin
            r_job_valid <= 1'b0;
            r_slot      <= kmng_pkg::SLOT_ROOT;
        end else if (w_out_load) begin
            r_slot      <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_req.load) begin
            r_job <= i_job_req.job;
        end
    end

    // Output register: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_msg.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_note_on  <= r_job.level;
            r_channel  <= i_channel;
            r_note     <= r_job.note + w_offset;
            r_velocity <= w_velocity;
            r_last     <= w_job_last;
        end
    end

    assign o_msg.valid        = r_out_valid;
    assign o_msg.note_on      = r_note_on;
    assign o_msg.out_channel  = r_channel;
    assign o_msg.note         = r_note;
    assign o_msg.out_velocity = r_velocity;
    assign o_msg.last         = r_last;

endmodule

[hdl/key_to_midi_note_generator.sv]
// Top level of the key to MIDI note generator.
//
// Usage:
//   i_req  carries key edges (action key edge, key, level, chord) and octave
//          up/down presses. A key edge for a key below NUM_KEYS yields one
//          note on/off message, or three when chord is set (root, +12, +19).
//          Octave presses and ignored requests yield no message.
//   o_msg  carries the messages; last marks the final message of a request.
//   APB    writes and reads channel (address 0) and velocity (address 4).
// Timing: an accepted key edge goes into the job register, and each of its
//   messages then into the output register. Throughput: one message per
//   cycle while o_msg.ready does not stall it; the job register and its slot
//   counter step a chord edge through its three messages. A new request is
//   taken as the last message of the current job is loaded.
// Stall: while o_msg.ready is low the output register holds its message and
//   i_req.ready falls as soon as the pending job cannot advance.
// Reset: channel 0, velocity 80, octave base 36, no keys held, both
//   channels empty; i_req.ready stays low while reset is held.
module key_to_midi_note_generator #(
    parameter int NUM_KEYS = kmng_pkg::NUM_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kmng_req_if.sink    i_req,
    kmng_msg_if.source  o_msg,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [3:0]             r_channel;
    logic [6:0]             r_velocity;

    // Octave base and held key map
    logic [6:0]             r_base;
    logic [6:0]             n_base;
    logic [NUM_KEYS-1:0]    r_held;
    logic [NUM_KEYS-1:0]    n_held;

    logic                   w_cfg_wr;
    logic                   w_accept;
    logic                   w_emit_ready;
    logic [NUM_KEYS-1:0]    w_key_sel;
    logic                   w_key_ok;
    logic                   w_none_held;
    kmng_pkg::t_job_req     w_job_req;

    // ---------------------------------------------------------------
    // APB port: zero wait states, register picked by paddr[2]
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel  <= kmng_pkg::CHAN_RESET;
            r_velocity <= kmng_pkg::VEL_RESET;
        end else if (w_cfg_wr) begin
            case (kmng_pkg::t_reg_idx'(paddr[2]))
                kmng_pkg::REG_CHANNEL:  r_channel  <= pwdata[3:0];
                kmng_pkg::REG_VELOCITY: r_velocity <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (kmng_pkg::t_reg_idx'(paddr[2]))
            kmng_pkg::REG_CHANNEL:  prdata = 32'(r_channel);
            kmng_pkg::REG_VELOCITY: prdata = 32'(r_velocity);
            default:                prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    // Hold off requests during reset so none is taken and then dropped.
    assign i_req.ready = w_emit_ready && i_rst_n;
    assign w_accept    = i_req.valid && i_req.ready;

    // One-hot key select; a key at or above NUM_KEYS selects nothing.
    always_comb begin
        for (int i = 0; i < NUM_KEYS; i++) begin
            w_key_sel[i] = (i_req.key == 4'(i));
        end
    end

    assign w_key_ok    = |w_key_sel;
    assign w_none_held = (r_held == '0);

    // Next octave base and held map for the request at the input.
    always_comb begin
        n_base = r_base;
        n_held = r_held;
        case (kmng_pkg::t_action'(i_req.action))
            kmng_pkg::ACT_KEY: begin
                if (i_req.level) begin
                    n_held = r_held | w_key_sel;
                end else begin
                    n_held = r_held & ~w_key_sel;
                end
            end
            kmng_pkg::ACT_OCT_UP: begin
                // Shift octave only with all keys up and below the ceiling
                if (w_none_held && (r_base < kmng_pkg::BASE_MAX)) begin
                    n_base = r_base + kmng_pkg::OCT_STEP;
                end
            end
            kmng_pkg::ACT_OCT_DOWN: begin
                if (w_none_held && (r_base > kmng_pkg::BASE_MIN)) begin
                    n_base = r_base - kmng_pkg::OCT_STEP;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= kmng_pkg::BASE_MIN;
            r_held <= '0;
        end else if (w_accept) begin
            r_base <= n_base;
            r_held <= n_held;
        end
    end

    // Hand a valid key edge to the emitter with its root note.
    always_comb begin
        w_job_req.load      = w_accept && w_key_ok &&
                              (kmng_pkg::t_action'(i_req.action) == kmng_pkg::ACT_KEY);
        w_job_req.job.note  = r_base + 7'(i_req.key);
        w_job_req.job.level = i_req.level;
        w_job_req.job.chord = i_req.chord;
    end

    kmng_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_req  (w_job_req),
        .i_channel  (r_channel),
        .i_velocity (r_velocity),
        .o_ready    (w_emit_ready),
        .o_msg      (o_msg)
    );

`ifndef SYNTHESIS
    // Octave base stays on one of the five legal octaves.
    a_base_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_base == 7'd36) || (r_base == 7'd48) || (r_base == 7'd60) ||
        (r_base == 7'd72) || (r_base == 7'd84))
        else $error("octave base left the legal set");

    // An octave press while a key is held leaves the base alone.
    a_base_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_none_held &&
         (kmng_pkg::t_action'(i_req.action) != kmng_pkg::ACT_KEY))
        |=> $stable(r_base))
        else $error("octave changed while keys were held");

    // A key edge that is not valid leaves the held map alone.
    a_held_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_job_req.load) |=> $stable(r_held))
        else $error("held map changed on an ignored request");
`endif

endmodule

[sim/kmng_note_check.sv]
// Watches the request, message and register channels, predicts every MIDI message and compares.
module kmng_note_check #(
    parameter int NUM_KEYS = kmng_pkg::NUM_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kmng_req_if         i_req,
    kmng_msg_if         i_msg,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       note_on;
        logic [3:0] channel;
        logic [6:0] note;
        logic [6:0] velocity;
        logic       last;
    } t_note_msg;

    logic [3:0]          chan_shadow;
    logic [6:0]          note_velocity;
    logic [6:0]          octave_base;
    logic [NUM_KEYS-1:0] held_keys;
    t_note_msg           expected_notes[$];
    int                  fail_count = 0;

    function automatic t_note_msg make_note(input logic on, input logic [6:0] note,
                                            input logic [6:0] vel, input logic last);
        t_note_msg m;
        m.note_on  = on;
        m.channel  = chan_shadow;
        m.note     = note;
        m.velocity = vel;
        m.last     = last;
        return m;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        fail_count++;
    endtask

    // Turn one accepted request into the messages it must produce.
    task automatic predict_notes(input logic [1:0] act, input logic [3:0] key,
                                 input logic lvl, input logic chord);
        logic [6:0] root;
        case (act)
            kmng_pkg::ACT_OCT_UP: begin
                if (held_keys == '0 && octave_base < kmng_pkg::BASE_MAX)
                    octave_base = octave_base + kmng_pkg::OCT_STEP;
            end
            kmng_pkg::ACT_OCT_DOWN: begin
                if (held_keys == '0 && octave_base > kmng_pkg::BASE_MIN)
                    octave_base = octave_base - kmng_pkg::OCT_STEP;
            end
            kmng_pkg::ACT_KEY: begin
                if (key < NUM_KEYS) begin
                    held_keys[key] = lvl;
                    root = octave_base + 7'(key);
                    expected_notes.push_back(make_note(lvl, root,
                                                       lvl ? note_velocity
                                                           : kmng_pkg::RELEASE_VEL,
                                                       !chord));
                    if (chord) begin
                        expected_notes.push_back(make_note(lvl, root + kmng_pkg::OCT_STEP,
                                                           note_velocity, 1'b0));
                        expected_notes.push_back(make_note(lvl, root + kmng_pkg::FIFTH_UP,
                                                           note_velocity, 1'b1));
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_note_msg want;
        logic [31:0] reg_value;
        if (!i_rst_n) begin
            chan_shadow   = kmng_pkg::CHAN_RESET;
            note_velocity = kmng_pkg::VEL_RESET;
            octave_base   = kmng_pkg::BASE_MIN;
            held_keys     = '0;
            expected_notes.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (kmng_pkg::t_reg_idx'(paddr[2]))
                        kmng_pkg::REG_CHANNEL:  chan_shadow   = pwdata[3:0];
                        kmng_pkg::REG_VELOCITY: note_velocity = pwdata[6:0];
                        default: ;
                    endcase
                end else begin
                    case (kmng_pkg::t_reg_idx'(paddr[2]))
                        kmng_pkg::REG_CHANNEL: reg_value = {28'd0, chan_shadow};
                        default:               reg_value = {25'd0, note_velocity};
                    endcase
                    if (prdata !== reg_value)
                        report_mismatch("register readback", reg_value, prdata);
                end
            end

            if (i_msg.valid && i_msg.ready) begin
                if (expected_notes.size() == 0) begin
                    $display("%0d ns: message with nothing pending, expected none, actual note %0d",
                             $time, i_msg.note);
                    fail_count++;
                end else begin
                    want = expected_notes.pop_front();
                    if (i_msg.note_on !== want.note_on)
                        report_mismatch("note_on", want.note_on, i_msg.note_on);
                    if (i_msg.out_channel !== want.channel)
                        report_mismatch("out_channel", want.channel, i_msg.out_channel);
                    if (i_msg.note !== want.note)
                        report_mismatch("note", want.note, i_msg.note);
                    if (i_msg.out_velocity !== want.velocity)
                        report_mismatch("out_velocity", want.velocity, i_msg.out_velocity);
                    if (i_msg.last !== want.last)
                        report_mismatch("last", want.last, i_msg.last);
                end
            end

            if (i_req.valid && i_req.ready)
                predict_notes(i_req.action, i_req.key, i_req.level, i_req.chord);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_notes.size();
    end

endmodule

[sim/key_to_midi_note_generator_test.sv]
// Top of the key to MIDI note generator testbench: clock, reset, stimulus and verdict.
module key_to_midi_note_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Action code the block must ignore.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Cycles to let pass after the last message before touching registers or ending.
    localparam int DRAIN_CYCLES = 8;
    // Length of the single long output stall that backs up the block.
    localparam int LONG_HOLD = 200;
    localparam int PHASE_ITEMS = 90;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    // Idle switches for sender and receiver, and the one-shot long output stall.
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit hold_output = 1'b0;

    // Stimulus-side view of held keys, used only to shape sensible sequences.
    logic [kmng_pkg::NUM_KEYS_DEF-1:0] held_view = '0;

    kmng_req_if req_bus ();
    kmng_msg_if msg_bus ();

    key_to_midi_note_generator uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_msg   (msg_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    kmng_note_check u_note_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_bus),
        .i_msg        (msg_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: mostly accept, sometimes drop ready for a burst, and once hold off
    // long enough that the block backs up into the request channel.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        msg_bus.ready <= 1'b0;
        forever begin
            if (hold_output && !hold_done) begin
                hold_done = 1'b1;
                msg_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                msg_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                msg_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Offer one request and hold it until the block takes it. An optional idle
    // burst goes in front so gaps land on every phase of message emission.
    task automatic send_request(input logic [1:0] act, input logic [3:0] key,
                                input logic lvl, input logic chord);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.action <= act;
        req_bus.key    <= key;
        req_bus.level  <= lvl;
        req_bus.chord  <= chord;
        do @(posedge clk); while (!req_bus.ready);
        if (act == kmng_pkg::ACT_KEY && key < kmng_pkg::NUM_KEYS_DEF)
            held_view[key] = lvl;
    endtask

    // Wait until every predicted message has come out, then let the pipe settle.
    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_access(input logic wr, input kmng_pkg::t_reg_idx idx,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write both registers and read them back while the block is quiet.
    task automatic configure(input logic [3:0] chan, input logic [6:0] vel);
        wait_idle();
        apb_access(1'b1, kmng_pkg::REG_CHANNEL, {28'd0, chan});
        apb_access(1'b1, kmng_pkg::REG_VELOCITY, {25'd0, vel});
        apb_access(1'b0, kmng_pkg::REG_CHANNEL, '0);
        apb_access(1'b0, kmng_pkg::REG_VELOCITY, '0);
    endtask

    // Random traffic: mostly key edges that follow the held state, with
    // release-all-then-octave sequences so the octave base actually moves.
    task automatic run_random(input int count);
        int sent;
        int roll;
        int k;
        logic [3:0] key;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                for (k = 0; k < kmng_pkg::NUM_KEYS_DEF; k++) begin
                    if (held_view[k]) begin
                        send_request(kmng_pkg::ACT_KEY, 4'(k), 1'b0, 1'($urandom));
                        sent++;
                    end
                end
                send_request(roll < 5 ? kmng_pkg::ACT_OCT_UP : kmng_pkg::ACT_OCT_DOWN,
                             4'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end else if (roll < 13) begin
                // octave press, likely skipped because keys are held
                send_request($urandom_range(0, 1) ? kmng_pkg::ACT_OCT_UP
                                                  : kmng_pkg::ACT_OCT_DOWN,
                             4'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end else if (roll < 17) begin
                // noise the block must drop; not counted
                if ($urandom_range(0, 1))
                    send_request(ACT_UNUSED, 4'($urandom), 1'($urandom), 1'($urandom));
                else
                    send_request(kmng_pkg::ACT_KEY,
                                 4'($urandom_range(kmng_pkg::NUM_KEYS_DEF, 15)),
                                 1'($urandom), 1'($urandom));
            end else begin
                key = 4'($urandom_range(0, kmng_pkg::NUM_KEYS_DEF - 1));
                send_request(kmng_pkg::ACT_KEY, key,
                             held_view[key] ? ($urandom_range(0, 3) == 0)
                                            : ($urandom_range(0, 3) != 0),
                             1'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        int i;
        rst_n          <= 1'b0;
        req_bus.valid  <= 1'b0;
        req_bus.action <= kmng_pkg::ACT_KEY;
        req_bus.key    <= '0;
        req_bus.level  <= 1'b0;
        req_bus.chord  <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings (channel 0, velocity 80, base 36).
        send_request(kmng_pkg::ACT_KEY, 4'd0, 1'b1, 1'b0);       // lowest key, plain press
        send_request(kmng_pkg::ACT_KEY, 4'd12, 1'b1, 1'b1);      // highest key, chord press
        send_request(kmng_pkg::ACT_OCT_UP, 4'd0, 1'b1, 1'b0);    // skipped: keys held
        send_request(kmng_pkg::ACT_OCT_DOWN, 4'd15, 1'b0, 1'b1); // skipped: held, at floor
        send_request(kmng_pkg::ACT_KEY, 4'd0, 1'b0, 1'b0);       // plain release, velocity 64
        send_request(kmng_pkg::ACT_KEY, 4'd12, 1'b0, 1'b1);      // chord release
        send_request(kmng_pkg::ACT_KEY, 4'd5, 1'b0, 1'b0);       // release of a key not held
        send_request(kmng_pkg::ACT_KEY, 4'd5, 1'b1, 1'b0);
        send_request(kmng_pkg::ACT_KEY, 4'd5, 1'b1, 1'b1);       // press of a key already held
        send_request(kmng_pkg::ACT_KEY, 4'd5, 1'b0, 1'b1);
        send_request(kmng_pkg::ACT_KEY, 4'd13, 1'b1, 1'b1);      // key out of range
        send_request(kmng_pkg::ACT_KEY, 4'd15, 1'b0, 1'b0);
        send_request(ACT_UNUSED, 4'd3, 1'b1, 1'b1);              // unused action
        // Walk the base to the top and one step past it; level must not matter.
        for (i = 0; i < 5; i++)
            send_request(kmng_pkg::ACT_OCT_UP, 4'($urandom), 1'(i), 1'($urandom));
        send_request(kmng_pkg::ACT_KEY, 4'd12, 1'b1, 1'b1);      // widest note numbers
        send_request(kmng_pkg::ACT_KEY, 4'd12, 1'b0, 1'b1);
        for (i = 0; i < 5; i++)
            send_request(kmng_pkg::ACT_OCT_DOWN, 4'($urandom), 1'(i), 1'($urandom));
        send_request(kmng_pkg::ACT_KEY, 4'd10, 1'b1, 1'b0);
        send_request(kmng_pkg::ACT_KEY, 4'd10, 1'b0, 1'b0);

        // Top settings, with the long output stall to back the block up.
        configure(4'd15, 7'd127);
        hold_output = 1'b1;
        run_random(PHASE_ITEMS);

        // Bottom settings.
        configure(4'd0, 7'd0);
        run_random(PHASE_ITEMS);

        configure(4'($urandom), 7'($urandom));
        run_random(PHASE_ITEMS);

        // Final stretch at full rate on both sides.
        configure(4'($urandom), 7'($urandom));
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_random(PHASE_ITEMS);

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("key_to_midi_note_generator_test passed");
        else
            $display("key_to_midi_note_generator_test failed");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("key_to_midi_note_generator_test failed");
        $finish;
    end

endmodule
